[rtl/rsa_pkg.sv]
// Package for the region slot allocator: widths, codes and state types.
`timescale 1ns / 1ps
package rsa_pkg;
	localparam int GRID_SIZE_DEF = 32;
	localparam int MAX_SLOTS_DEF = 256;
	localparam int MAP_TYPES_DEF = 4;
	localparam int MIN_CAPACITY = 4;

	typedef enum logic [2:0] {
		ACT_ACQUIRE = 3'd0,
		ACT_RELEASE = 3'd1,
		ACT_RESET = 3'd2,
		ACT_MARK = 3'd3,
		ACT_CLEAN = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_RESIDENT = 3'd1,
		ST_RELEASED = 3'd2,
		ST_NOT_RESIDENT = 3'd3,
		ST_OUT_OF_BOUNDS = 3'd4,
		ST_NO_FREE = 3'd5,
		ST_DONE = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_READ,
		FSM_WRITE,
		FSM_OUT,
		FSM_CLEAR
	} fsm_t;
endpackage

[rtl/region_slot_allocator_unit.sv]
// Top level of the region slot allocator.
`timescale 1ns / 1ps
// Hands out stable slots to grid locations: acquire, release, reset all, mark dirty, clean.
// A request is accepted only while idle and then passes in order through accept, memory
// read, decision and write back, and result, which is held until m_tready is high. The
// grid map and the per-slot dirty masks sit in synchronous memories. Free slots are kept
// as a high-water mark (slots never handed out since the last reset all, up to the
// capacity) under a stack of released slots, which pops in the same order as one LIFO
// stack. Growth only raises the capacity, since slots above it are never written. After
// arst_n, and after a reset-all request once its result is taken, both memories are
// cleared one entry per cycle over max(GRID_SIZE*GRID_SIZE, MAX_SLOTS) entries (1024
// with the defaults) while s_tready stays low.
module region_slot_allocator_unit
	import rsa_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int MAP_TYPES = MAP_TYPES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[2:0], region_x[10:3], region_y[18:11], slot_sel[26:19], map_mask[30:27]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], slot[10:3], grew[11], capacity[20:12], map_index[30:21], dirty_bits[34:31]
	output logic [39:0] m_tdata
);
	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int MW = $clog2(CELLS);
	localparam int SW = $clog2(MAX_SLOTS);
	localparam int CW = SW + 1;
	localparam int CLR_N = (CELLS > MAX_SLOTS) ? CELLS : MAX_SLOTS;
	localparam int KW = $clog2(CLR_N);

	fsm_t state_q, state_d;

	// grid map memory: slot+1, zero when not resident
	logic [CW-1:0] map_mem [CELLS];
	logic [MAP_TYPES-1:0] dirty_mem [MAX_SLOTS];
	// released slot stack
	logic [SW-1:0] rel_mem [MAX_SLOTS];

	logic [CW-1:0] cap_q, hw_q, rel_cnt_q;
	logic [KW-1:0] clr_idx_q;
	logic clr_last;

	logic [2:0] act_q;
	logic [7:0] x_q, y_q, sel_q;
	logic [MAP_TYPES-1:0] mask_q;
	logic [CW-1:0] map_rd_s1;
	logic [MAP_TYPES-1:0] dirty_rd_s1;
	logic [SW-1:0] rel_rd_s1;

	logic [2:0] o_status_q;
	logic [7:0] o_slot_q;
	logic o_grew_q;
	logic [8:0] o_cap_q;
	logic [9:0] o_midx_q;
	logic [3:0] o_dirty_q;

	// location decode
	logic signed [9:0] gx, gy;
	logic inb;
	logic [MW-1:0] midx;
	always_comb begin
		gx = 10'(signed'(x_q)) + 10'(GRID_SIZE / 2);
		gy = 10'(signed'(y_q)) + 10'(GRID_SIZE / 2);
		inb = (gx >= 0) && (gx < 10'(GRID_SIZE)) && (gy >= 0) && (gy < 10'(GRID_SIZE));
		midx = MW'(int'(gy) * GRID_SIZE + int'(gx));
	end

	logic [CW-1:0] entry;
	logic [SW-1:0] dslot;
	logic sel_ok;
	always_comb begin
		entry = map_rd_s1;
		dslot = SW'(entry - CW'(1));
		sel_ok = int'(sel_q) < int'(cap_q);
	end

	assign clr_last = (clr_idx_q == KW'(CLR_N - 1));

	// growth
	logic [CW:0] gcap;
	always_comb begin
		gcap = (CW+1)'(cap_q < CW'(MIN_CAPACITY) ? CW'(MIN_CAPACITY) : cap_q);
		if (gcap <= (CW+1)'(cap_q)) gcap = gcap << 1;
		if (gcap > (CW+1)'(MAX_SLOTS)) gcap = (CW+1)'(MAX_SLOTS);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (s_tvalid) state_d = FSM_READ;
			FSM_READ: state_d = FSM_WRITE;
			FSM_WRITE: state_d = FSM_OUT;
			FSM_OUT: if (m_tready) state_d = (act_q == ACT_RESET) ? FSM_CLEAR : FSM_IDLE;
			FSM_CLEAR: if (clr_last) state_d = FSM_IDLE;
			default: state_d = FSM_IDLE;
		endcase
	end

	assign s_tready = (state_q == FSM_IDLE);
	assign m_tvalid = (state_q == FSM_OUT);
	assign m_tdata = {5'd0, o_dirty_q, o_midx_q, o_cap_q, o_grew_q, o_slot_q, o_status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_CLEAR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && s_tvalid) begin
			act_q <= s_tdata[2:0];
			x_q <= s_tdata[10:3];
			y_q <= s_tdata[18:11];
			sel_q <= s_tdata[26:19];
			mask_q <= s_tdata[27 +: MAP_TYPES];
		end
	end

	// memory reads in READ, valid in WRITE
	always_ff @(posedge clk) begin
		map_rd_s1 <= map_mem[midx];
		dirty_rd_s1 <= dirty_mem[SW'(sel_q)];
		rel_rd_s1 <= rel_mem[SW'(rel_cnt_q - CW'(1))];
	end

	// decisions in WRITE
	logic [SW-1:0] s_new;
	logic have;
	logic do_grow;
	logic [CW-1:0] cap_n;
	always_comb begin
		do_grow = (rel_cnt_q == '0) && (hw_q == cap_q) && (gcap > (CW+1)'(cap_q));
		cap_n = do_grow ? CW'(gcap) : cap_q;
		have = (rel_cnt_q != '0) || (hw_q < cap_n);
		s_new = (rel_cnt_q != '0) ? rel_rd_s1 : SW'(hw_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0; hw_q <= '0; rel_cnt_q <= '0; clr_idx_q <= '0;
		end else if (state_q == FSM_CLEAR) begin
			clr_idx_q <= clr_last ? '0 : clr_idx_q + KW'(1);
		end else if (state_q == FSM_WRITE) begin
			unique case (act_q)
				ACT_ACQUIRE: if (inb && entry == '0) begin
					if (do_grow) begin
						cap_q <= cap_n;
					end
					if (have) begin
						if (rel_cnt_q != '0) rel_cnt_q <= rel_cnt_q - CW'(1);
						else hw_q <= hw_q + CW'(1);
					end
				end
				ACT_RELEASE: if (inb && entry != '0) begin
					rel_cnt_q <= rel_cnt_q + CW'(1);
				end
				ACT_RESET: begin
					hw_q <= '0;
					rel_cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// writes
	logic [MAP_TYPES-1:0] dnew;
	always_comb begin
		dnew = dirty_rd_s1;
		if (act_q == ACT_MARK) dnew = dirty_rd_s1 | mask_q;
		else if (act_q == ACT_CLEAN) dnew = dirty_rd_s1 & ~mask_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_CLEAR) begin
			if (int'(clr_idx_q) < CELLS) map_mem[MW'(clr_idx_q)] <= '0;
			if (int'(clr_idx_q) < MAX_SLOTS) dirty_mem[SW'(clr_idx_q)] <= '0;
		end else if (state_q == FSM_WRITE) begin
			unique case (act_q)
				ACT_ACQUIRE: if (inb) begin
					if (entry != '0) begin
						dirty_mem[dslot] <= '1;
					end else if (have) begin
						map_mem[midx] <= CW'(s_new) + CW'(1);
						dirty_mem[s_new] <= '1;
					end
				end
				ACT_RELEASE: if (inb && entry != '0) begin
					map_mem[midx] <= '0;
					dirty_mem[dslot] <= '0;
					rel_mem[SW'(rel_cnt_q)] <= dslot;
				end
				ACT_MARK, ACT_CLEAN: if (sel_ok)
					dirty_mem[SW'(sel_q)] <= dnew;
				default: ;
			endcase
		end
	end

	// result
	always_ff @(posedge clk) begin
		if (state_q == FSM_WRITE) begin
			o_status_q <= ST_DONE; o_slot_q <= '0; o_grew_q <= 1'b0;
			o_midx_q <= '0; o_dirty_q <= '0; o_cap_q <= 9'(cap_q);
			unique case (act_q)
				ACT_ACQUIRE: if (!inb) o_status_q <= ST_OUT_OF_BOUNDS;
				else begin
					o_midx_q <= 10'(midx);
					if (entry != '0) begin
						o_status_q <= ST_RESIDENT; o_slot_q <= 8'(dslot);
						o_dirty_q <= 4'({MAP_TYPES{1'b1}});
					end else begin
						o_grew_q <= do_grow; o_cap_q <= 9'(cap_n);
						if (have) begin
							o_status_q <= ST_ALLOCATED; o_slot_q <= 8'(s_new);
							o_dirty_q <= 4'({MAP_TYPES{1'b1}});
						end else o_status_q <= ST_NO_FREE;
					end
				end
				ACT_RELEASE: if (!inb) o_status_q <= ST_OUT_OF_BOUNDS;
				else begin
					o_midx_q <= 10'(midx);
					if (entry == '0) o_status_q <= ST_NOT_RESIDENT;
					else begin
						o_status_q <= ST_RELEASED; o_slot_q <= 8'(dslot);
					end
				end
				ACT_MARK, ACT_CLEAN: if (sel_ok) begin
					o_slot_q <= sel_q; o_dirty_q <= 4'(dnew);
				end else o_status_q <= ST_OUT_OF_BOUNDS;
				default: ;
			endcase
		end
	end
endmodule
